// File: hw/rtl/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types, widths and codes for the array priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int PAYLOAD_W     = 32;
  localparam int PRIO_W        = 32;
  localparam int OCC_W         = 8;
  localparam int STATUS_W      = 2;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQ   = 2'd0,
    ST_FULL  = 2'd1,
    ST_DEQ   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic sample;
    logic first;
  } pick_ctl_t;

endpackage

// File: hw/rtl/array_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// array_priority_queue_unit
// Priority queue over an unsorted store kept in arrival order.
// ----------------------------------------------------------------------------
// One request is handled at a time. An enqueue or a rejected request goes
// from S_START to S_DONE and on to the output register. A dequeue scans
// the n stored entries for the highest priority (earliest wins ties), then
// moves every later entry down one place; the scan and the shift both go
// through the single read port of the entry store, one entry a cycle. A
// finished result waits in the output register while the next request is
// accepted.
module array_priority_queue_unit #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               req_type,
  input  logic [apq_pkg::PAYLOAD_W-1:0]      payload,
  input  logic signed [apq_pkg::PRIO_W-1:0]  priority_req,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [apq_pkg::STATUS_W-1:0]       status,
  output logic [apq_pkg::PAYLOAD_W-1:0]      payload_out,
  output logic [apq_pkg::OCC_W-1:0]          occupancy
);
  import apq_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MEM_W = PRIO_W + PAYLOAD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t                   state;
  logic                     req_q;
  logic [PAYLOAD_W-1:0]     payload_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            rd_idx;
  logic                     pend;
  logic [AW-1:0]            pend_idx;
  status_t                  res_status;
  logic [PAYLOAD_W-1:0]     res_payload;
  status_t                  status_q;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [MEM_W-1:0]         wr_data;
  logic                     rd_en;
  logic [MEM_W-1:0]         rd_data;
  logic signed [PRIO_W-1:0] rd_prio;
  logic [PAYLOAD_W-1:0]     rd_payload;
  pick_ctl_t                pick_ctl;
  logic [AW-1:0]            best_idx;
  logic [PAYLOAD_W-1:0]     best_payload;

  assign in_stall   = (state != S_IDLE);
  assign status     = status_q;
  assign rd_prio    = $signed(rd_data[MEM_W-1 -: PRIO_W]);
  assign rd_payload = rd_data[PAYLOAD_W-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = {prio_q, payload_q};
    case (state)
      S_START: begin
        if (req_q == REQ_ENQ && count < CW'(DEPTH)) begin
          wr_en   = 1'b1;
          wr_addr = count[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - AW'(1);
          wr_data = rd_data;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_en           = (state == S_SCAN || state == S_SHIFT) && (rd_idx < count);
  assign pick_ctl.sample = (state == S_SCAN) && pend;
  assign pick_ctl.first  = (pend_idx == '0);

  apq_mem #(
    .DEPTH (DEPTH),
    .W     (MEM_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  apq_pick #(
    .DEPTH (DEPTH)
  ) u_pick (
    .clk          (clk),
    .ctl          (pick_ctl),
    .idx          (pend_idx),
    .prio         (rd_prio),
    .pay          (rd_payload),
    .best_idx     (best_idx),
    .best_payload (best_payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q     <= req_type;
            payload_q <= payload;
            prio_q    <= priority_req;
            state     <= S_START;
          end
        end
        S_START: begin
          res_payload <= '0;
          if (req_q == REQ_ENQ) begin
            if (count < CW'(DEPTH)) begin
              count      <= count + CW'(1);
              res_status <= ST_ENQ;
            end else begin
              res_status <= ST_FULL;
            end
            state <= S_DONE;
          end else if (count == '0) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else begin
            rd_idx <= '0;
            pend   <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend     <= rd_en;
          pend_idx <= rd_idx[AW-1:0];
          if (rd_en) begin
            rd_idx <= rd_idx + CW'(1);
          end else if (!pend) begin
            rd_idx <= CW'(best_idx) + CW'(1);
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          pend     <= rd_en;
          pend_idx <= rd_idx[AW-1:0];
          if (rd_en) begin
            rd_idx <= rd_idx + CW'(1);
          end else if (!pend) begin
            count       <= count - CW'(1);
            res_status  <= ST_DEQ;
            res_payload <= best_payload;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            status_q    <= res_status;
            payload_out <= res_payload;
            occupancy   <= OCC_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("item count above depth");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_START || state == S_SHIFT))
    else $error("store written outside enqueue or shift");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && pend) |-> (pend_idx != '0))
    else $error("shift write address underflow");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status_q == ST_EMPTY) |-> (payload_out == '0))
    else $error("empty result carries a payload");

endmodule

// File: hw/rtl/apq_mem.sv
// ----------------------------------------------------------------------------
// apq_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module apq_mem #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT,
  parameter int W     = apq_pkg::PRIO_W + apq_pkg::PAYLOAD_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);
  import apq_pkg::*;

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/apq_pick.sv
// ----------------------------------------------------------------------------
// apq_pick
// Compare unit: keeps the best entry seen during a scan.
// ----------------------------------------------------------------------------
module apq_pick #(
  parameter int DEPTH = apq_pkg::DEPTH_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                                 clk,
  input  apq_pkg::pick_ctl_t                   ctl,
  input  logic [AW-1:0]                        idx,
  input  logic signed [apq_pkg::PRIO_W-1:0]    prio,
  input  logic [apq_pkg::PAYLOAD_W-1:0]        pay,
  output logic [AW-1:0]                        best_idx,
  output logic [apq_pkg::PAYLOAD_W-1:0]        best_payload
);
  import apq_pkg::*;

  logic signed [PRIO_W-1:0] best_prio;

  // strict greater keeps the earliest entry on ties
  always_ff @(posedge clk) begin
    if (ctl.sample && (ctl.first || (prio > best_prio))) begin
      best_prio    <= prio;
      best_idx     <= idx;
      best_payload <= pay;
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the array priority queue unit. A driver feeds
// enqueue and dequeue transactions from a pending list with random gaps. A
// behavioral queue model predicts status, payload and occupancy for every
// accepted request, and a monitor compares each returned result in order
// while stalling the output at random, once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import apq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int N_ITEMS = 850;
  localparam int TAIL_CYCLES = 2 * DEPTH + 16;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int LONG_HOLD_AFTER = 300;

  typedef struct {
    logic                      req;
    logic [PAYLOAD_W-1:0]      tag;
    logic signed [PRIO_W-1:0]  prio;
    int                        gap;
  } request_t;

  typedef struct {
    status_t                   status;
    logic [PAYLOAD_W-1:0]      tag;
    logic [OCC_W-1:0]          occupancy;
  } outcome_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      req_type = REQ_ENQ;
  logic [PAYLOAD_W-1:0]      payload = '0;
  logic signed [PRIO_W-1:0]  priority_req = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic [PAYLOAD_W-1:0]      payload_out;
  logic [OCC_W-1:0]          occupancy;

  array_priority_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .payload      (payload),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .payload_out  (payload_out),
    .occupancy    (occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // queue model state
  logic [PAYLOAD_W-1:0]      model_tags [DEPTH];
  logic signed [PRIO_W-1:0]  model_prios [DEPTH];
  int                        model_count = 0;

  request_t  pending_requests [$];
  outcome_t  expected_results [$];
  int        error_count = 0;
  int        results_checked = 0;

  function automatic void predict_request(logic req, logic [PAYLOAD_W-1:0] tag,
                                          logic signed [PRIO_W-1:0] prio);
    outcome_t res;
    int best;
    res.tag = '0;
    if (req == REQ_ENQ) begin
      if (model_count < DEPTH) begin
        model_tags[model_count] = tag;
        model_prios[model_count] = prio;
        model_count++;
        res.status = ST_ENQ;
      end else begin
        res.status = ST_FULL;
      end
    end else if (model_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < model_count; i++)
        if (model_prios[i] > model_prios[best]) best = i;
      res.tag = model_tags[best];
      for (int i = best; i + 1 < model_count; i++) begin
        model_tags[i] = model_tags[i + 1];
        model_prios[i] = model_prios[i + 1];
      end
      model_count--;
      res.status = ST_DEQ;
    end
    res.occupancy = OCC_W'(model_count);
    expected_results.push_back(res);
  endfunction

  // stimulus shaping
  int  plan_count = 0;
  bit  tx_quiet = 1'b0;

  task automatic add_request(logic req, logic [PAYLOAD_W-1:0] tag,
                             logic signed [PRIO_W-1:0] prio);
    request_t r;
    r.req = req;
    r.tag = tag;
    r.prio = prio;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    r.gap = tx_quiet ? 0 : $urandom_range(0, 7);
    pending_requests.push_back(r);
    if (req == REQ_ENQ && plan_count < DEPTH) plan_count++;
    if (req == REQ_DEQ && plan_count > 0) plan_count--;
  endtask

  function automatic logic signed [PRIO_W-1:0] draw_prio();
    logic signed [PRIO_W-1:0] p;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = $signed(PRIO_W'($urandom_range(0, 15))) - 8;
      4:          p = {1'b0, {(PRIO_W-1){1'b1}}};
      5:          p = {1'b1, {(PRIO_W-1){1'b0}}};
      default:    p = $signed(PRIO_W'($urandom));
    endcase
    return p;
  endfunction

  function automatic logic [PAYLOAD_W-1:0] draw_tag();
    logic [PAYLOAD_W-1:0] t;
    case ($urandom_range(0, 19))
      0:       t = '0;
      1:       t = '1;
      default: t = PAYLOAD_W'($urandom);
    endcase
    return t;
  endfunction

  initial begin
    int seg;
    int n;
    // directed part: empty, extremes, ties
    add_request(REQ_DEQ, 32'h0, 32'sh0);
    add_request(REQ_ENQ, 32'h0000_0000, 32'sh8000_0000);
    add_request(REQ_ENQ, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    add_request(REQ_ENQ, 32'h0000_1234, 32'sh0);
    add_request(REQ_ENQ, 32'h0000_5555, -32'sd1);
    add_request(REQ_ENQ, 32'hAAAA_0001, 32'sd7);
    add_request(REQ_ENQ, 32'hAAAA_0002, 32'sd7);
    add_request(REQ_ENQ, 32'hAAAA_0003, 32'sd7);
    add_request(REQ_ENQ, 32'h5555_AAAA, 32'sh7FFF_FFFF);
    for (int i = 0; i < 8; i++)
      add_request(REQ_DEQ, PAYLOAD_W'($urandom), $signed(PRIO_W'($urandom)));
    add_request(REQ_DEQ, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    add_request(REQ_ENQ, 32'hDEAD_BEEF, 32'sd1);
    add_request(REQ_DEQ, 32'hFFFF_FFFF, -32'sd1);
    add_request(REQ_DEQ, 32'h0, 32'sh0);
    // random part: mixed traffic, fill past full, drain past empty
    seg = 0;
    while (pending_requests.size() < N_ITEMS) begin
      case (seg % 4)
        0, 2: begin
          n = $urandom_range(80, 140);
          for (int i = 0; i < n; i++)
            if ($urandom_range(0, 99) < 55)
              add_request(REQ_ENQ, draw_tag(), draw_prio());
            else
              add_request(REQ_DEQ, draw_tag(), draw_prio());
        end
        1: begin
          n = DEPTH - plan_count + $urandom_range(1, 4);
          for (int i = 0; i < n; i++) add_request(REQ_ENQ, draw_tag(), draw_prio());
        end
        default: begin
          n = plan_count + $urandom_range(1, 3);
          for (int i = 0; i < n; i++) add_request(REQ_DEQ, draw_tag(), draw_prio());
        end
      endcase
      seg++;
    end
  end

  // driver
  int  wait_cycles = 0;
  bit  take_next;
  request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      wait_cycles = 0;
    end else begin
      take_next = !in_valid;
      if (in_valid && !in_stall) begin
        predict_request(req_type, payload, priority_req);
        take_next = 1'b1;
      end
      if (take_next) begin
        if (pending_requests.size() > 0 && wait_cycles < pending_requests[0].gap) begin
          wait_cycles++;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          req_type <= next_req.req;
          payload <= next_req.tag;
          priority_req <= next_req.prio;
          in_valid <= 1'b1;
          wait_cycles = 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the unit backs up into its input
  logic hold_off = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
      hold_left = 0;
    end else if (!hold_done && results_checked >= LONG_HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES;
      hold_off <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      hold_off <= (hold_left > 0);
    end
  end

  // monitor
  int        stall_cycles = 0;
  bit        rx_quiet = 1'b0;
  outcome_t  want;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: status %0d payload_out %h occupancy %0d",
                 status, payload_out, occupancy);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            error_count++;
          end
          if (payload_out !== want.tag) begin
            $error("payload_out: expected %h, got %h", want.tag, payload_out);
            error_count++;
          end
          if (occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy);
            error_count++;
          end
        end
        results_checked <= results_checked + 1;
        if ($urandom_range(0, 49) == 0) rx_quiet = !rx_quiet;
        stall_cycles = rx_quiet ? 0 : $urandom_range(0, 7);
      end
      if (stall_cycles > 0) begin
        stall_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    while (pending_requests.size() > 0 || in_valid || expected_results.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
